// ===== src/thl_pkg.sv =====
`default_nettype none

package thl_pkg;

    localparam int unsigned DELAY_W   = 16;
    localparam int unsigned TIMEOUT_W = 24;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 24;

    localparam logic [DELAY_W-1:0]   BIT_DELAY_RESET = 16'd500;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 24'd1000000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_DELAY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 8'd1;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_SEND  = 2'd1,
        OP_RECV  = 2'd2,
        OP_PROBE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_TIMEOUT  = 2'd1,
        STAT_MISMATCH = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_TX_LOW   = 4'd1,
        PH_TX_HIGH  = 4'd2,
        PH_TX_DELAY = 4'd3,
        PH_RX_ANY   = 4'd4,
        PH_RX_ACK   = 4'd5,
        PH_RX_DELAY = 4'd6,
        PH_PROBE    = 4'd7
    } phase_t;

    // Drive value: bit 0 releases line A, bit 1 releases line B.
    localparam logic [1:0] DRV_RELEASE = 2'b11;
    localparam logic [1:0] DRV_PULL_A  = 2'b10;
    localparam logic [1:0] DRV_PULL_B  = 2'b01;

    // Sensed lines packed as {sense_b, sense_a}.
    localparam logic [1:0] LINES_BOTH_HIGH = 2'b11;
    localparam logic [1:0] LINES_A_HIGH    = 2'b01;

    // Expected sensed lines for each probe drive pattern.
    localparam logic [1:0] PROBE_EXPECT [4] = '{2'b00, 2'b10, 2'b01, 2'b11};

    typedef struct packed {
        logic [DELAY_W-1:0]   bit_delay;
        logic [TIMEOUT_W-1:0] timeout;
    } thl_cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic       sense_a;
        logic       sense_b;
    } thl_item_t;

    typedef struct packed {
        logic       drive_a_release;
        logic       drive_b_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic [1:0] status;
    } thl_result_t;

endpackage

`default_nettype wire

// ===== src/thl_engine.sv =====
`default_nettype none

module thl_engine
    import thl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire thl_item_t   item,
    input  wire thl_cfg_t    cfg,
    output thl_result_t      result
);

    phase_t               phase_reg, phase_next;
    logic [2:0]           bit_count_reg, bit_count_next;
    logic [7:0]           shift_reg, shift_next;
    logic [TIMEOUT_W-1:0] wait_count_reg, wait_count_next;
    logic [DELAY_W-1:0]   delay_count_reg, delay_count_next;
    logic [1:0]           drive_reg, drive_next;
    logic [1:0]           probe_step_reg, probe_step_next;

    logic [TIMEOUT_W-1:0] wait_inc;
    logic                 wait_expired;
    logic [1:0]           lines;
    logic                 lvl;
    logic                 nb_req;
    logic                 nb_tx;
    logic                 done;
    logic [1:0]           status;
    logic [7:0]           rx;

    assign lines        = {item.sense_b, item.sense_a};
    assign wait_inc     = wait_count_reg + 1'b1;
    assign wait_expired = (wait_inc >= cfg.timeout);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            shift_reg       <= '0;
            wait_count_reg  <= '0;
            delay_count_reg <= '0;
            drive_reg       <= DRV_RELEASE;
            probe_step_reg  <= 2'd3;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
            wait_count_reg  <= wait_count_next;
            delay_count_reg <= delay_count_next;
            drive_reg       <= drive_next;
            probe_step_reg  <= probe_step_next;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        wait_count_next  = wait_count_reg;
        delay_count_next = delay_count_reg;
        drive_next       = drive_reg;
        probe_step_next  = probe_step_reg;
        nb_req           = 1'b0;
        nb_tx            = 1'b0;
        done             = 1'b0;
        status           = STAT_OK;
        rx               = '0;
        lvl              = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                unique case (item.op)
                    OP_SEND:
                    begin
                        shift_next      = item.tx_byte;
                        bit_count_next  = '0;
                        wait_count_next = '0;
                        drive_next      = item.tx_byte[0] ? DRV_PULL_A : DRV_PULL_B;
                        phase_next      = PH_TX_LOW;
                    end
                    OP_RECV:
                    begin
                        shift_next      = '0;
                        bit_count_next  = '0;
                        wait_count_next = '0;
                        drive_next      = DRV_RELEASE;
                        phase_next      = PH_RX_ANY;
                    end
                    OP_PROBE:
                    begin
                        probe_step_next  = 2'd3;
                        drive_next       = DRV_RELEASE;
                        delay_count_next = cfg.bit_delay;
                        phase_next       = PH_PROBE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            PH_TX_LOW:
            begin
                lvl = shift_reg[0] ? item.sense_a : item.sense_b;
                if (!lvl)
                begin
                    drive_next      = DRV_RELEASE;
                    wait_count_next = '0;
                    phase_next      = PH_TX_HIGH;
                end
                else
                begin
                    wait_count_next = wait_inc;
                    if (wait_expired)
                    begin
                        drive_next = DRV_RELEASE;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                        status     = STAT_TIMEOUT;
                    end
                end
            end
            PH_TX_HIGH:
            begin
                lvl = shift_reg[0] ? item.sense_a : item.sense_b;
                if (lvl)
                begin
                    shift_next = {1'b0, shift_reg[7:1]};
                    drive_next = DRV_RELEASE;
                    if (cfg.bit_delay == '0)
                    begin
                        nb_req = 1'b1;
                        nb_tx  = 1'b1;
                    end
                    else
                    begin
                        delay_count_next = cfg.bit_delay;
                        phase_next       = PH_TX_DELAY;
                    end
                end
                else
                begin
                    wait_count_next = wait_inc;
                    if (wait_expired)
                    begin
                        drive_next = DRV_RELEASE;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                        status     = STAT_TIMEOUT;
                    end
                end
            end
            PH_RX_ANY:
            begin
                if (lines != LINES_BOTH_HIGH)
                begin
                    wait_count_next = '0;
                    // Line B low alone carries a 1; anything else with A low is a 0.
                    if (lines == LINES_A_HIGH)
                    begin
                        shift_next = {1'b1, shift_reg[7:1]};
                        drive_next = DRV_PULL_B;
                    end
                    else
                    begin
                        shift_next = {1'b0, shift_reg[7:1]};
                        drive_next = DRV_PULL_A;
                    end
                    phase_next = PH_RX_ACK;
                end
                else
                begin
                    wait_count_next = wait_inc;
                    if (wait_expired)
                    begin
                        drive_next = DRV_RELEASE;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                        status     = STAT_TIMEOUT;
                    end
                end
            end
            PH_RX_ACK:
            begin
                lvl = (drive_reg == DRV_PULL_B) ? item.sense_b : item.sense_a;
                if (lvl)
                begin
                    drive_next = DRV_RELEASE;
                    if (cfg.bit_delay == '0)
                    begin
                        nb_req = 1'b1;
                    end
                    else
                    begin
                        delay_count_next = cfg.bit_delay;
                        phase_next       = PH_RX_DELAY;
                    end
                end
                else
                begin
                    wait_count_next = wait_inc;
                    if (wait_expired)
                    begin
                        drive_next = DRV_RELEASE;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                        status     = STAT_TIMEOUT;
                    end
                end
            end
            PH_TX_DELAY, PH_RX_DELAY:
            begin
                if (delay_count_reg != '0)
                begin
                    delay_count_next = delay_count_reg - 1'b1;
                end
                if (delay_count_next == '0)
                begin
                    nb_req = 1'b1;
                    nb_tx  = (phase_reg == PH_TX_DELAY);
                end
            end
            PH_PROBE:
            begin
                if (delay_count_reg != '0)
                begin
                    delay_count_next = delay_count_reg - 1'b1;
                end
                else if (lines != PROBE_EXPECT[probe_step_reg])
                begin
                    drive_next = DRV_RELEASE;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                    status     = STAT_MISMATCH;
                end
                else if (probe_step_reg == 2'd0)
                begin
                    drive_next = DRV_RELEASE;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                else
                begin
                    probe_step_next  = probe_step_reg - 1'b1;
                    drive_next       = probe_step_reg - 1'b1;
                    delay_count_next = cfg.bit_delay;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                drive_next = DRV_RELEASE;
            end
        endcase

        // Step to the next bit, or finish the byte after the eighth one.
        if (nb_req)
        begin
            if (bit_count_reg >= 3'd7)
            begin
                if (!nb_tx)
                begin
                    rx = shift_next;
                end
                drive_next = DRV_RELEASE;
                phase_next = PH_IDLE;
                done       = 1'b1;
                status     = STAT_OK;
            end
            else
            begin
                bit_count_next  = bit_count_reg + 1'b1;
                wait_count_next = '0;
                if (nb_tx)
                begin
                    drive_next = shift_next[0] ? DRV_PULL_A : DRV_PULL_B;
                    phase_next = PH_TX_LOW;
                end
                else
                begin
                    phase_next = PH_RX_ANY;
                end
            end
        end
    end

    always_comb
    begin
        result.drive_a_release = drive_next[0];
        result.drive_b_release = drive_next[1];
        result.busy_res        = (phase_next != PH_IDLE);
        result.done_res        = done;
        result.rx_byte         = rx;
        result.status          = status;
    end

endmodule

`default_nettype wire

// ===== src/two_wire_handshake_link.sv =====
// Two-wire handshake link engine. Every transfer on the input channel is one
// clock tick of the link: an optional command (send a byte, receive a byte or
// probe the cable) together with the sensed levels of lines A and B. Every
// input transfer yields exactly one result transfer that shows the drive
// levels, busy, a done pulse, the received byte and a status after that tick.
// Commands that arrive while a command is in progress are ignored. Bytes go
// LSB first; each bit and each probe step is followed by bit_delay_ticks idle
// ticks, and each handshake wait ends in a timeout status after timeout_ticks
// failing ticks, with both lines released. A new input transfer is accepted
// in every cycle: the item passes an input register, the engine updates
// its state in the same clock as the result lands in an output register,
// and throughput is one item per cycle whenever the downstream
// side keeps taking results. Configuration writes (index 0 for
// bit_delay_ticks, index 1 for timeout_ticks, other indexes ignored) are
// always accepted and should be made while the block is idle.

`default_nettype none

module two_wire_handshake_link
    import thl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           op,
    input  wire logic [7:0]           tx_byte,
    input  wire logic                 sense_a,
    input  wire logic                 sense_b,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      drive_a_release,
    output logic                      drive_b_release,
    output logic                      busy_res,
    output logic                      done_res,
    output logic [7:0]                rx_byte,
    output logic [1:0]                status,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    thl_cfg_t    cfg_reg;
    thl_item_t   item_reg;
    logic        item_valid_reg;
    thl_result_t result_reg;
    logic        out_valid_reg;
    thl_result_t result;
    logic        advance;

    // The input register moves into the engine whenever the output register
    // is empty or its result is being taken in this same cycle.
    assign advance   = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_delay <= BIT_DELAY_RESET;
            cfg_reg.timeout   <= TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_BIT_DELAY)
            begin
                cfg_reg.bit_delay <= cfg_data[DELAY_W-1:0];
            end
            else if (cfg_index == CFG_TIMEOUT)
            begin
                cfg_reg.timeout <= cfg_data[TIMEOUT_W-1:0];
            end
        end
    end

    // Input register: control state only is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op      <= op;
            item_reg.tx_byte <= tx_byte;
            item_reg.sense_a <= sense_a;
            item_reg.sense_b <= sense_b;
        end
    end

    thl_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Output register: holds a result until the downstream side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign drive_a_release = result_reg.drive_a_release;
    assign drive_b_release = result_reg.drive_b_release;
    assign busy_res        = result_reg.busy_res;
    assign done_res        = result_reg.done_res;
    assign rx_byte         = result_reg.rx_byte;
    assign status          = result_reg.status;

endmodule

`default_nettype wire

// ===== src/thl_checker.sv =====
`default_nettype none

module thl_checker
    import thl_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       drive_a_release,
    input wire logic       drive_b_release,
    input wire logic       busy_res,
    input wire logic       done_res,
    input wire logic [7:0] rx_byte,
    input wire logic [1:0] status
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(rx_byte)
            && $stable(done_res) && $stable(busy_res))
        else $error("result changed while stalled");

    // Received byte and status are zero except on a done transfer.
    a_quiet_when_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> status == STAT_OK && rx_byte == 8'd0)
        else $error("status or byte without done");

    // A finished command leaves the engine idle.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("busy on done transfer");

    // Any error releases both lines.
    a_error_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> drive_a_release && drive_b_release)
        else $error("line held after error");

    // An error status never comes with received data.
    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_TIMEOUT || status == STAT_MISMATCH) |-> rx_byte == 8'd0)
        else $error("data reported with error");

endmodule

bind two_wire_handshake_link thl_checker u_thl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .drive_a_release (drive_a_release),
    .drive_b_release (drive_b_release),
    .busy_res        (busy_res),
    .done_res        (done_res),
    .rx_byte         (rx_byte),
    .status          (status)
);

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

// Testbench for the two-wire handshake link engine.
//
// Every transfer on the input channel is one tick of the link, and every tick
// yields exactly one result transfer. The bench keeps its own cycle model of
// the engine. That model is advanced once for each accepted tick, and it
// produces the result that the block must return for that tick. Results are
// checked in order against a queue of these expectations.
//
// The sensed line levels are not plain noise. Each tick is built from the
// state that the model predicts after the previous tick, so the far end of
// the cable mostly answers the way a partner device would: it pulls and
// releases the awaited line, presents a bit when a byte is being received,
// and returns the expected levels for each probe step. A tunable share of
// ticks withholds the answer, which brings out the timeout paths, and
// another share is fully random.

module tb;
    import thl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int DIR_ROWS       = 22;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           op = OP_NONE;
    logic [7:0]           tx_byte = 8'h00;
    logic                 sense_a = 1'b1;
    logic                 sense_b = 1'b1;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 drive_a_release;
    logic                 drive_b_release;
    logic                 busy_res;
    logic                 done_res;
    logic [7:0]           rx_byte;
    logic [1:0]           status;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BIT_DELAY;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    two_wire_handshake_link u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .tx_byte         (tx_byte),
        .sense_a         (sense_a),
        .sense_b         (sense_b),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .drive_a_release (drive_a_release),
        .drive_b_release (drive_b_release),
        .busy_res        (busy_res),
        .done_res        (done_res),
        .rx_byte         (rx_byte),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 2 ns clock period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cycle model of the engine. It holds its own copy of the registers
    // and of the engine state, and it is advanced once per accepted tick.
    // ------------------------------------------------------------------
    logic [DELAY_W-1:0]   lk_bit_delay;
    logic [TIMEOUT_W-1:0] lk_timeout;
    phase_t               lk_phase;
    logic [2:0]           lk_bits;
    logic [7:0]           lk_shift;
    logic [TIMEOUT_W-1:0] lk_wait;
    logic [DELAY_W-1:0]   lk_delay;
    logic [1:0]           lk_drive;
    logic [1:0]           lk_step;

    // Per-tick result flags, cleared at the start of every tick.
    logic                 lk_done;
    status_t              lk_status;
    logic [7:0]           lk_rx;

    thl_result_t          pending_res[$];

    task automatic lk_reset();
        lk_bit_delay = BIT_DELAY_RESET;
        lk_timeout   = TIMEOUT_RESET;
        lk_phase     = PH_IDLE;
        lk_bits      = '0;
        lk_shift     = '0;
        lk_wait      = '0;
        lk_delay     = '0;
        lk_drive     = DRV_RELEASE;
        lk_step      = 2'd3;
    endtask

    // Ends the running command: both lines are released.
    task automatic lk_close(input status_t code);
        lk_drive  = DRV_RELEASE;
        lk_phase  = PH_IDLE;
        lk_done   = 1'b1;
        lk_status = code;
    endtask

    // One failing tick of a handshake wait; true once the budget is spent.
    function automatic logic lk_wait_spent();
        lk_wait = lk_wait + 1'b1;
        return lk_wait >= lk_timeout;
    endfunction

    task automatic lk_next_bit(input logic sending);
        if (lk_bits == 3'd7)
        begin
            if (!sending)
                lk_rx = lk_shift;
            lk_close(STAT_OK);
        end
        else
        begin
            lk_bits = lk_bits + 1'b1;
            lk_wait = '0;
            if (sending)
            begin
                lk_drive = lk_shift[0] ? DRV_PULL_A : DRV_PULL_B;
                lk_phase = PH_TX_LOW;
            end
            else
                lk_phase = PH_RX_ANY;
        end
    endtask

    // A completed bit releases the lines; with no bit delay the next bit
    // starts right away.
    task automatic lk_end_bit(input logic sending);
        lk_drive = DRV_RELEASE;
        if (lk_bit_delay == '0)
            lk_next_bit(sending);
        else
        begin
            lk_delay = lk_bit_delay;
            lk_phase = sending ? PH_TX_DELAY : PH_RX_DELAY;
        end
    endtask

    task automatic link_tick(input thl_item_t t, output thl_result_t r);
        logic [1:0] lines;
        logic       lvl;
        lines     = {t.sense_b, t.sense_a};
        lk_done   = 1'b0;
        lk_status = STAT_OK;
        lk_rx     = 8'h00;
        case (lk_phase)
            PH_IDLE:
            begin
                case (t.op)
                    OP_SEND:
                    begin
                        lk_shift = t.tx_byte;
                        lk_bits  = '0;
                        lk_wait  = '0;
                        lk_drive = t.tx_byte[0] ? DRV_PULL_A : DRV_PULL_B;
                        lk_phase = PH_TX_LOW;
                    end
                    OP_RECV:
                    begin
                        lk_shift = '0;
                        lk_bits  = '0;
                        lk_wait  = '0;
                        lk_drive = DRV_RELEASE;
                        lk_phase = PH_RX_ANY;
                    end
                    OP_PROBE:
                    begin
                        lk_step  = 2'd3;
                        lk_drive = DRV_RELEASE;
                        lk_delay = lk_bit_delay;
                        lk_phase = PH_PROBE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            PH_TX_LOW:
            begin
                lvl = lk_shift[0] ? t.sense_a : t.sense_b;
                if (!lvl)
                begin
                    lk_drive = DRV_RELEASE;
                    lk_wait  = '0;
                    lk_phase = PH_TX_HIGH;
                end
                else if (lk_wait_spent())
                    lk_close(STAT_TIMEOUT);
            end
            PH_TX_HIGH:
            begin
                lvl = lk_shift[0] ? t.sense_a : t.sense_b;
                if (lvl)
                begin
                    lk_shift = lk_shift >> 1;
                    lk_end_bit(1'b1);
                end
                else if (lk_wait_spent())
                    lk_close(STAT_TIMEOUT);
            end
            PH_RX_ANY:
            begin
                if (lines != LINES_BOTH_HIGH)
                begin
                    lk_wait = '0;
                    // Line B low alone is a 1 bit; any other low is a 0 bit.
                    if (lines == LINES_A_HIGH)
                    begin
                        lk_shift = {1'b1, lk_shift[7:1]};
                        lk_drive = DRV_PULL_B;
                    end
                    else
                    begin
                        lk_shift = {1'b0, lk_shift[7:1]};
                        lk_drive = DRV_PULL_A;
                    end
                    lk_phase = PH_RX_ACK;
                end
                else if (lk_wait_spent())
                    lk_close(STAT_TIMEOUT);
            end
            PH_RX_ACK:
            begin
                lvl = (lk_drive == DRV_PULL_B) ? t.sense_b : t.sense_a;
                if (lvl)
                    lk_end_bit(1'b0);
                else if (lk_wait_spent())
                    lk_close(STAT_TIMEOUT);
            end
            PH_TX_DELAY, PH_RX_DELAY:
            begin
                if (lk_delay != '0)
                    lk_delay = lk_delay - 1'b1;
                if (lk_delay == '0)
                    lk_next_bit(lk_phase == PH_TX_DELAY);
            end
            PH_PROBE:
            begin
                if (lk_delay != '0)
                    lk_delay = lk_delay - 1'b1;
                else if (lines != PROBE_EXPECT[lk_step])
                    lk_close(STAT_MISMATCH);
                else if (lk_step == 2'd0)
                    lk_close(STAT_OK);
                else
                begin
                    lk_step  = lk_step - 1'b1;
                    lk_drive = lk_step;
                    lk_delay = lk_bit_delay;
                end
            end
            default:
            begin
                lk_phase = PH_IDLE;
                lk_drive = DRV_RELEASE;
            end
        endcase
        r.drive_a_release = lk_drive[0];
        r.drive_b_release = lk_drive[1];
        r.busy_res        = (lk_phase != PH_IDLE);
        r.done_res        = lk_done;
        r.rx_byte         = lk_rx;
        r.status          = lk_status;
    endtask

    // ------------------------------------------------------------------
    // Tick generation. The far end answers the awaited condition with
    // probability meet_pct; noise_pct of the ticks are fully random.
    // Commands are random on every tick, so most of them arrive while the
    // engine is busy and must be ignored.
    // ------------------------------------------------------------------
    function automatic thl_item_t make_tick(input int meet_pct, input int noise_pct);
        thl_item_t t;
        logic      meet;
        t.op      = 2'($urandom_range(3));
        t.tx_byte = 8'($urandom);
        t.sense_a = 1'($urandom);
        t.sense_b = 1'($urandom);
        if ($urandom_range(99) < noise_pct)
            return t;
        meet = ($urandom_range(99) < meet_pct);
        case (lk_phase)
            PH_TX_LOW:
                if (lk_shift[0])
                    t.sense_a = !meet;
                else
                    t.sense_b = !meet;
            PH_TX_HIGH:
                if (lk_shift[0])
                    t.sense_a = meet;
                else
                    t.sense_b = meet;
            PH_RX_ANY:
                // A bit is one line low, or both low; both high means no bit.
                if (meet)
                    {t.sense_b, t.sense_a} = 2'($urandom_range(2));
                else
                    {t.sense_b, t.sense_a} = LINES_BOTH_HIGH;
            PH_RX_ACK:
                if (lk_drive == DRV_PULL_B)
                    t.sense_b = meet;
                else
                    t.sense_a = meet;
            PH_PROBE:
                if (lk_delay == '0 && meet)
                    {t.sense_b, t.sense_a} = PROBE_EXPECT[lk_step];
            default:
            begin
            end
        endcase
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Idle gaps on the input side: mostly none or short, a few long, and
    // now and then a stretch of back-to-back transfers.
    // ------------------------------------------------------------------
    int   calm_left = 0;
    logic gaps_off = 1'b0;

    function automatic int pick_gap();
        int unsigned r;
        if (gaps_off)
            return 0;
        if (calm_left != 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 94)
            return $urandom_range(8, 25);
        calm_left = $urandom_range(20, 60);
        return 0;
    endfunction

    // The receiving side stalls on its own schedule: long ready stretches,
    // short stalls, and the odd long one.
    int out_hold = 0;

    always @(negedge clk)
    begin
        if (out_hold != 0)
            out_hold--;
        else if ($urandom_range(99) < 55)
        begin
            out_ready <= 1'b1;
            out_hold = $urandom_range(1, 40);
        end
        else
        begin
            out_ready <= 1'b0;
            out_hold = ($urandom_range(99) < 8) ? $urandom_range(10, 30)
                                                : $urandom_range(0, 2);
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks. Inputs change only at the falling edge, and handshakes
    // are judged on the values seen at the rising edge.
    // ------------------------------------------------------------------
    int n_ticks = 0;

    task automatic send_tick(input thl_item_t t);
        int          gap;
        thl_result_t r;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        op       <= t.op;
        tx_byte  <= t.tx_byte;
        sense_a  <= t.sense_a;
        sense_b  <= t.sense_b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        link_tick(t, r);
        pending_res.push_back(r);
        n_ticks++;
    endtask

    // Takes valid down after the last transfer so nothing is sent twice.
    task automatic hold_off();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_res.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_BIT_DELAY)
            lk_bit_delay = val[DELAY_W-1:0];
        else if (idx == CFG_TIMEOUT)
            lk_timeout = val[TIMEOUT_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Lets the running command finish with a fully cooperative far end, then
    // waits for every outstanding result so the registers can be rewritten.
    task automatic settle_idle();
        while (lk_phase != PH_IDLE)
            send_tick(make_tick(100, 0));
        hold_off();
        wait_drained();
    endtask

    task automatic run_phase(input logic [DELAY_W-1:0] bit_delay,
                             input logic [TIMEOUT_W-1:0] timeout,
                             input int meet_pct, input int noise_pct,
                             input int count);
        settle_idle();
        write_reg(CFG_BIT_DELAY, CFG_DAT_W'(bit_delay));
        write_reg(CFG_TIMEOUT, timeout);
        for (int i = 0; i < count; i++)
        begin
            // Now and then the sender waits for the result queue to empty.
            if (i == count / 2 || $urandom_range(199) == 0)
            begin
                hold_off();
                wait_drained();
            end
            send_tick(make_tick(meet_pct, noise_pct));
        end
    endtask

    // ------------------------------------------------------------------
    // Directed ticks, run with no bit delay and a timeout of one tick.
    // Rows with a typed result are checked against that value; the others
    // are checked against the model.
    // ------------------------------------------------------------------
    typedef struct packed {
        thl_item_t   tick;
        logic        typed;
        thl_result_t want;
    } dir_row_t;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // Idle tick: both lines released, nothing busy.
        '{'{OP_NONE,  8'h00, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, STAT_OK}},
        // Probe that walks all four patterns and passes.
        '{'{OP_PROBE, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,  8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,  8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_NONE,  8'h00, 1'b0, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,  8'h00, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, STAT_OK}},
        // Probe mismatch on the first compare, with a send ignored meanwhile.
        '{'{OP_PROBE, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_SEND,  8'hFF, 1'b0, 1'b0}, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, STAT_MISMATCH}},
        // Send of all ones; line A never answers.
        '{'{OP_SEND,  8'hFF, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,  8'h00, 1'b1, 1'b1}, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, STAT_TIMEOUT}},
        // Receive where both lines go low, taken as a 0 bit, then a timeout.
        '{'{OP_RECV,  8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,  8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_NONE,  8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,  8'h00, 1'b1, 1'b1}, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, STAT_TIMEOUT}},
        // Send of all zeros: one bit on line B, then the next bit times out.
        '{'{OP_SEND,  8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,  8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_NONE,  8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,  8'h00, 1'b1, 1'b1}, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, STAT_TIMEOUT}},
        // Receive of a 1 bit whose acknowledge never completes.
        '{'{OP_RECV,  8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,  8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_NONE,  8'h00, 1'b1, 1'b0}, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, STAT_TIMEOUT}},
        // Idle with both lines sensed low.
        '{'{OP_NONE,  8'h00, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, STAT_OK}}
    };

    // ------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------
    int n_errors   = 0;
    int n_reported = 0;
    int n_results  = 0;
    int n_ok       = 0;
    int n_timeouts = 0;
    int n_mismatch = 0;

    always @(posedge clk)
    begin
        thl_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (done_res)
            begin
                if (status == STAT_OK)
                    n_ok++;
                else if (status == STAT_TIMEOUT)
                    n_timeouts++;
                else
                    n_mismatch++;
            end
            if (pending_res.size() == 0)
            begin
                n_errors++;
                if (n_reported < REPORT_LIMIT)
                begin
                    n_reported++;
                    $display("%0t: result transfer with no expectation waiting", $realtime);
                end
            end
            else
            begin
                want = pending_res.pop_front();
                if (want.drive_a_release != drive_a_release ||
                    want.drive_b_release != drive_b_release ||
                    want.busy_res != busy_res || want.done_res != done_res ||
                    want.rx_byte != rx_byte || want.status != status)
                begin
                    n_errors++;
                    if (n_reported < REPORT_LIMIT)
                    begin
                        n_reported++;
                        $display("%0t: result %0d expected drv=%b%b busy=%b done=%b rx=%h st=%0d",
                                 $realtime, n_results, want.drive_b_release,
                                 want.drive_a_release, want.busy_res, want.done_res,
                                 want.rx_byte, want.status);
                        $display("%0t: result %0d actual   drv=%b%b busy=%b done=%b rx=%h st=%0d",
                                 $realtime, n_results, drive_b_release, drive_a_release,
                                 busy_res, done_res, rx_byte, status);
                    end
                end
            end
        end
    end

    // Watchdog: the run ends if no transfer happens on any channel for too
    // long. Every stall the bench creates is far shorter than the limit.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        lk_reset();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed ticks with the smallest settings.
        write_reg(CFG_BIT_DELAY, '0);
        write_reg(CFG_TIMEOUT, CFG_DAT_W'(1));
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_tick(dir_rows[i].tick);
            if (dir_rows[i].typed)
                pending_res[$] = dir_rows[i].want;
        end

        // Random ticks under several settings, the largest timeout among them.
        run_phase(16'd0, 24'd3, 95, 5, 250);
        run_phase(16'd2, 24'd5, 85, 10, 250);
        run_phase(16'd1, 24'hFFFFFF, 80, 10, 150);
        run_phase(16'd5, 24'd2, 70, 15, 200);
        run_phase(16'd9, 24'd12, 90, 5, 150);

        // Long bit delay: a probe with both lines idle high passes the
        // first pattern and fails the second after the full delay. The
        // ticks go back to back here.
        settle_idle();
        write_reg(CFG_BIT_DELAY, CFG_DAT_W'(16'd100));
        write_reg(CFG_TIMEOUT, CFG_DAT_W'(1));
        gaps_off = 1'b1;
        send_tick('{OP_PROBE, 8'h5A, 1'b1, 1'b1});
        while (lk_phase != PH_IDLE)
            send_tick('{2'($urandom_range(3)), 8'($urandom), 1'b1, 1'b1});
        gaps_off = 1'b0;

        // Wait for the last results and a few more cycles for strays.
        hold_off();
        wait_drained();
        repeat (8) @(posedge clk);
        if (pending_res.size() != 0)
            n_errors += pending_res.size();

        $display("Checked %0d ticks; commands ended %0d ok, %0d by timeout, %0d by probe mismatch.",
                 n_ticks, n_ok, n_timeouts, n_mismatch);
        $display("Bit delays 0 to 100 and timeouts 1 to 16777215 were used; %0d errors.",
                 n_errors);
        if (n_errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/thl_pkg.sv
src/thl_engine.sv
src/two_wire_handshake_link.sv
src/thl_checker.sv
verif/tb.sv
